### rtl/shp_pkg.sv
// Shared types and constants for the 3x3 sharpen stream block.
package shp_pkg;

  localparam int SHP_MAX_WIDTH = 4096;   // default line store depth
  localparam int PIX_W         = 8;
  localparam int COORD_W       = 12;
  localparam int DIM_W         = 13;
  localparam int DIM_LIMIT     = 4096;   // largest frame side the counters cover

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
  localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(3);

  typedef logic [PIX_W-1:0] pix_t;

  // One window column: top is the oldest row, bot the arriving row.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } pix_col_t;

  // One line store word: both stored rows at one column.
  typedef struct packed {
    pix_t line1;   // previous row
    pix_t line0;   // row before that
  } line_pair_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

endpackage

### rtl/sharpen_3x3_stream.sv
// Top level of the streaming 3x3 sharpen filter with its register port.
//
// Grey 8-bit pixels enter in raster order, one transfer per clock at full
// rate, and each interior pixel leaves as a transfer carrying the kernel
// result (9 times the centre minus the eight neighbours, clamped to 0..255),
// its row and column, and tlast on the last interior pixel of the frame.
// Border pixels are not sent. An input transfer with tuser set starts a new
// frame at (0,0); after the bottom right pixel the position wraps by itself.
// Each result passes, in order, the registered line store read, the shift of
// the window column chain, and the sum and clamp into the output queue. The
// line store is a single memory of MAX_WIDTH words holding both previous
// rows, read and rewritten once per pixel, so the block takes one pixel every
// clock while s_tready is high. A four-entry output queue with credit
// accounting absorbs downstream stalls; s_tready drops only when the queue
// and the results in flight would fill it. No clearing pass is run after
// reset. image_width (address 0) and image_height (address 4) are saturated
// to 3..min(MAX_WIDTH,4096) and 3..4096; write them only while no pixel is
// in flight.
module sharpen_3x3_stream
  import shp_pkg::*;
#(
  parameter int MAX_WIDTH = SHP_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  // pixel input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] pixel_in
  input  logic        s_tuser,    // [0] frame_start
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [7:0] pixel_out, [19:8] out_row, [31:20] out_col
  output logic        m_tlast,    // out_last
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_WIDTH);
  // one bit above both the column and the address so MAX_WIDTH itself fits
  localparam int XW = ((AW > COORD_W) ? AW : COORD_W) + 1;
  localparam logic [DIM_W-1:0] LIMIT_W =
    DIM_W'((MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT);
  localparam logic [DIM_W-1:0] LIMIT_H = DIM_W'(DIM_LIMIT);
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = QPW + 1;

  typedef struct packed {
    logic               last;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    pix_t               pix;
  } out_item_t;

  // ---------------------------------------------------------------- registers
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  // saturate the frame size into the supported range
  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;

  always_comb begin
    eff_w = image_width;
    if (image_width < DIM_MIN) begin
      eff_w = DIM_MIN;
    end else if (image_width > LIMIT_W) begin
      eff_w = LIMIT_W;
    end
    eff_h = image_height;
    if (image_height < DIM_MIN) begin
      eff_h = DIM_MIN;
    end else if (image_height > LIMIT_H) begin
      eff_h = LIMIT_H;
    end
  end

  // ---------------------------------------------------------------- position
  logic               accept;
  logic [COORD_W-1:0] col_count, col_count_next;
  logic [COORD_W-1:0] row_count, row_count_next;
  logic [COORD_W-1:0] cur_col, cur_row;
  logic [DIM_W-1:0]   col_inc, row_inc;
  logic               cur_emit, cur_last;
  logic [XW-1:0]      col_x;
  logic [AW-1:0]      cur_addr;

  assign accept = s_tvalid && s_tready;

  always_comb begin
    // frame start forces the arriving pixel to (0,0)
    cur_col = s_tuser ? '0 : col_count;
    cur_row = s_tuser ? '0 : row_count;
    col_inc = {1'b0, cur_col} + DIM_W'(1);
    row_inc = {1'b0, cur_row} + DIM_W'(1);

    cur_emit = (cur_row >= COORD_W'(2)) && (cur_col >= COORD_W'(2));
    cur_last = (row_inc == eff_h) && (col_inc == eff_w);

    // wrap at the limit, also when the size shrank under a running count
    if (col_inc >= eff_w) begin
      col_count_next = '0;
      row_count_next = (row_inc >= eff_h) ? '0 : row_inc[COORD_W-1:0];
    end else begin
      col_count_next = col_inc[COORD_W-1:0];
      row_count_next = cur_row;
    end

    col_x = XW'(cur_col);
    if (col_x >= XW'(MAX_WIDTH)) begin
      col_x = XW'(MAX_WIDTH - 1);
    end
    cur_addr = col_x[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // line store read in flight; write back the shifted rows next cycle
  logic               s1_valid;
  logic               s1_emit;
  logic               s1_last;
  logic [COORD_W-1:0] s1_row, s1_col;
  pix_t               s1_px;
  logic [AW-1:0]      s1_addr;
  line_pair_t         rd_pair;
  line_pair_t         wr_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_emit  <= accept && cur_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= cur_last;
      s1_row  <= cur_row - COORD_W'(1);
      s1_col  <= cur_col - COORD_W'(1);
      s1_px   <= s_tdata;
      s1_addr <= cur_addr;
    end
  end

  assign wr_pair.line1 = s1_px;
  assign wr_pair.line0 = rd_pair.line1;

  shp_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (cur_addr),
    .rd_data (rd_pair),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_data (wr_pair)
  );

  // ---------------------------------------------------------------- window
  // chain[1] is the newest column, chain[3] the oldest
  pix_col_t chain [4];

  assign chain[0].top = rd_pair.line0;
  assign chain[0].mid = rd_pair.line1;
  assign chain[0].bot = s1_px;

  for (genvar i = 0; i < 3; i++) begin : g_win
    shp_win_cell u_col (
      .clk   (clk),
      .rst   (rst),
      .shift (s1_valid),
      .din   (chain[i]),
      .dout  (chain[i+1])
    );
  end

  // ---------------------------------------------------------------- stage 2
  logic               s2_emit;
  logic               s2_last;
  logic [COORD_W-1:0] s2_row, s2_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_emit <= 1'b0;
    end else begin
      s2_emit <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_last <= s1_last;
      s2_row  <= s1_row;
      s2_col  <= s1_col;
    end
  end

  // 9 * centre minus the eight neighbours, then clamp
  logic [11:0]        ctr9;
  logic [10:0]        nb_sum;
  logic signed [12:0] diff;
  pix_t               sharp;

  always_comb begin
    ctr9   = {chain[2].mid, 3'b000} + 12'(chain[2].mid);
    nb_sum = 11'(chain[1].top) + 11'(chain[1].mid) + 11'(chain[1].bot)
           + 11'(chain[2].top) + 11'(chain[2].bot)
           + 11'(chain[3].top) + 11'(chain[3].mid) + 11'(chain[3].bot);
    diff   = $signed({1'b0, ctr9}) - $signed({2'b00, nb_sum});
    if (diff < 0) begin
      sharp = '0;
    end else if (diff > 13'sd255) begin
      sharp = '1;
    end else begin
      sharp = diff[7:0];
    end
  end

  // ---------------------------------------------------------------- output queue
  out_item_t        q_mem [QDEPTH];
  logic [QPW-1:0]   q_wr_ptr, q_rd_ptr;
  logic [QCW-1:0]   q_count;
  logic [QCW-1:0]   q_pending;
  logic             q_push, q_pop;
  out_item_t        q_in, q_head;

  assign q_push = s2_emit;
  assign q_pop  = m_tvalid && m_tready;

  assign q_in.last = s2_last;
  assign q_in.col  = s2_col;
  assign q_in.row  = s2_row;
  assign q_in.pix  = sharp;

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr_ptr] <= q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= '0;
      q_rd_ptr <= '0;
      q_count  <= '0;
    end else begin
      if (q_push) begin
        q_wr_ptr <= q_wr_ptr + QPW'(1);
      end
      if (q_pop) begin
        q_rd_ptr <= q_rd_ptr + QPW'(1);
      end
      q_count <= q_count + QCW'(q_push) - QCW'(q_pop);
    end
  end

  // reserve a slot for every result still in the pipeline
  assign q_pending = q_count + QCW'(s1_emit) + QCW'(s2_emit);
  assign s_tready  = q_pending < QCW'(QDEPTH);

  assign q_head   = q_mem[q_rd_ptr];
  assign m_tvalid = q_count != '0;
  assign m_tdata  = {q_head.col, q_head.row, q_head.pix};
  assign m_tlast  = q_head.last;

`ifndef SYNTH
  // queue plus results in flight never overrun the queue
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    q_pending <= QCW'(QDEPTH))
    else $error("output queue credit overrun");

  // a push never lands on a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < QCW'(QDEPTH)))
    else $error("push into full output queue");

  // every accepted pixel shifts the window in the next cycle
  a_window_shift: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel did not reach the window");

  // an interior result never carries row zero or column zero
  a_interior: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((q_head.row != '0) && (q_head.col != '0)))
    else $error("border coordinate on output");
`endif

endmodule

### rtl/shp_win_cell.sv
// One column cell of the 3x3 window shift chain.
module shp_win_cell
  import shp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     shift,
  input  pix_col_t din,
  output pix_col_t dout
);

  // advance one column per pixel, hold otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (shift) begin
      dout <= din;
    end
  end

endmodule

### rtl/shp_line_mem.sv
// Two-row line store: one word per column, registered read with write bypass.
module shp_line_mem
  import shp_pkg::*;
#(
  parameter int DEPTH = SHP_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output line_pair_t               rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  line_pair_t               wr_data
);

  line_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // forward a write in flight to the same column
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule
